@@ rtl/clpd_pkg.sv @@
// clpd_pkg: shared widths, register indexes and pipeline cell types
// for the color line projection distance core; no dependencies
`default_nettype none

package clpd_pkg;

    localparam int FRACTION_BITS = 4;

    localparam int COLOR_W = 8;
    localparam int DD_W    = 18;                      // d.d and divisor width
    localparam int NUM_W   = 38;                      // |P-B|^2 * d.d
    localparam int LOW_W   = 20;                      // bits of num below the first remainder
    localparam int Q_W     = LOW_W + 2 * FRACTION_BITS; // quotient width
    localparam int R_W     = Q_W / 2;                 // root width
    localparam int DIST_W  = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BG_BLUE      = 3'd0,
        REG_BG_GREEN     = 3'd1,
        REG_BG_RED       = 3'd2,
        REG_FINGER_BLUE  = 3'd3,
        REG_FINGER_GREEN = 3'd4,
        REG_FINGER_RED   = 3'd5
    } cfg_reg_t;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic             degen;
        logic [DD_W-1:0]  rem;
        logic [DD_W-1:0]  dd;
        logic [Q_W-1:0]   qx;     // dividend bits shift out, quotient bits shift in
    } div_data_t;

    typedef struct packed {
        logic             degen;
        logic [R_W:0]     rem;
        logic [R_W-1:0]   root;
        logic [Q_W-1:0]   xs;     // radicand, two bits leave per cell
    } sqrt_data_t;

endpackage

`default_nettype wire

@@ rtl/clpd_front.sv @@
// clpd_front: four-stage front end, builds the line and the scaled
// squared distance numerator; uses clpd_pkg
`default_nettype none

module clpd_front
    import clpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire color_t    pix [3],
    input  wire color_t    bg [3],
    input  wire color_t    finger [3],
    output logic           out_valid,
    output div_data_t      out_data
);

    logic [DD_W-1:0] nb;
    logic [DD_W-1:0] nf;
    logic            start_finger;
    color_t          s [3];
    color_t          o [3];

    logic [3:0] valid_reg;

    color_t              d_reg [3];
    logic signed [8:0]   g_reg [3];
    logic signed [8:0]   cs_reg [3];

    logic [DD_W-1:0]     dd_next, dd_reg, dd2_reg;
    logic signed [18:0]  n_next, n_reg;
    logic signed [18:0]  gg_next;
    logic [DD_W-1:0]     gg_reg;
    logic signed [18:0]  gd_next, gd_reg;

    logic [35:0]         p1_next, p1_reg;
    logic signed [37:0]  p2_next, p2_reg;
    logic signed [37:0]  p3_next, p3_reg;

    logic signed [39:0]  num;
    logic [NUM_W-1:0]    numc;
    div_data_t           div_next, div_reg;

    always_comb
    begin
        nb = DD_W'(bg[0] * bg[0]) + DD_W'(bg[1] * bg[1]) + DD_W'(bg[2] * bg[2]);
        nf = DD_W'(finger[0] * finger[0]) + DD_W'(finger[1] * finger[1])
           + DD_W'(finger[2] * finger[2]);
        start_finger = !(nb < nf);
        for (int i = 0; i < 3; i++)
        begin
            s[i] = start_finger ? finger[i] : bg[i];
            o[i] = start_finger ? bg[i] : finger[i];
        end
    end

    // stage a: direction, start offset and pixel offset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= (o[i] > s[i]) ? color_t'(o[i] - s[i]) : '0;
                g_reg[i]  <= $signed({1'b0, s[i]}) - $signed({1'b0, bg[i]});
                cs_reg[i] <= $signed({1'b0, pix[i]}) - $signed({1'b0, s[i]});
            end
        end
    end

    // stage b: dot products
    always_comb
    begin
        dd_next = DD_W'(d_reg[0] * d_reg[0]) + DD_W'(d_reg[1] * d_reg[1])
                + DD_W'(d_reg[2] * d_reg[2]);
        n_next  = $signed({1'b0, d_reg[0]}) * cs_reg[0]
                + $signed({1'b0, d_reg[1]}) * cs_reg[1]
                + $signed({1'b0, d_reg[2]}) * cs_reg[2];
        gg_next = g_reg[0] * g_reg[0] + g_reg[1] * g_reg[1] + g_reg[2] * g_reg[2];
        gd_next = $signed({1'b0, d_reg[0]}) * g_reg[0]
                + $signed({1'b0, d_reg[1]}) * g_reg[1]
                + $signed({1'b0, d_reg[2]}) * g_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg <= dd_next;
            n_reg  <= n_next;
            gg_reg <= gg_next[DD_W-1:0];
            gd_reg <= gd_next;
        end
    end

    // stage c: the three wide products
    always_comb
    begin
        p1_next = 36'(gg_reg) * 36'(dd_reg);
        p2_next = 38'(n_reg) * 38'(gd_reg);
        p3_next = 38'(n_reg) * 38'(n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            dd2_reg <= dd_reg;
        end
    end

    // stage d: numerator sum, clamp, seed the divider
    always_comb
    begin
        num  = $signed({4'b0, p1_reg}) + $signed({p2_reg[37], p2_reg, 1'b0})
             + $signed({{2{p3_reg[37]}}, p3_reg});
        numc = num[39] ? '0 : num[NUM_W-1:0];
        div_next.degen = (dd2_reg == '0);
        div_next.dd    = dd2_reg;
        div_next.rem   = numc[NUM_W-1:LOW_W];
        div_next.qx    = Q_W'({numc[LOW_W-1:0], {(2 * FRACTION_BITS){1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = div_reg;

endmodule

`default_nettype wire

@@ rtl/clpd_div_cell.sv @@
// clpd_div_cell: one restoring division step, one quotient bit per cell
// uses clpd_pkg
`default_nettype none

module clpd_div_cell
    import clpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire div_data_t in_data,
    output logic           out_valid,
    output div_data_t      out_data
);

    logic [DD_W:0] shifted;
    logic          ge;
    div_data_t     data_next;
    div_data_t     data_reg;
    logic          valid_reg;

    always_comb
    begin
        shifted   = {in_data.rem, in_data.qx[Q_W-1]};
        ge        = shifted >= {1'b0, in_data.dd};
        data_next = in_data;
        data_next.rem = ge ? DD_W'(shifted - {1'b0, in_data.dd}) : DD_W'(shifted);
        data_next.qx  = {in_data.qx[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/clpd_sqrt_cell.sv @@
// clpd_sqrt_cell: one digit-by-digit square root step, one root bit per cell
// uses clpd_pkg
`default_nettype none

module clpd_sqrt_cell
    import clpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire sqrt_data_t in_data,
    output logic            out_valid,
    output sqrt_data_t      out_data
);

    logic [R_W+2:0] shifted;
    logic [R_W+2:0] trial;
    logic           ge;
    sqrt_data_t     data_next;
    sqrt_data_t     data_reg;
    logic           valid_reg;

    always_comb
    begin
        shifted   = {in_data.rem, in_data.xs[Q_W-1:Q_W-2]};
        trial     = {1'b0, in_data.root, 2'b01};
        ge        = shifted >= trial;
        data_next = in_data;
        data_next.rem  = ge ? (R_W+1)'(shifted - trial) : (R_W+1)'(shifted);
        data_next.root = {in_data.root[R_W-2:0], ge};
        data_next.xs   = {in_data.xs[Q_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/color_line_projection_distance_core.sv @@
// color_line_projection_distance_core: top level, config registers,
// front end, divider and square root cell chains; uses clpd_pkg and all clpd modules
`default_nettype none

// Projects each pixel onto the color line through the background and finger
// colors and returns the distance from the background color to the projected
// point as unsigned 12.4 fixed point (floor), never saturating as the root is
// narrower than the output. The start of the line is the color with the
// smaller squared norm (finger on a tie); the direction is clamped to
// non-negative components, and a zero direction gives distance 0 with
// degenerate_line set. One transaction is accepted every clock while no
// finished result waits under out_stall. Each result passes through the
// four front-end stages, the divider chain with one cell per quotient bit
// and the square root chain with one cell per root bit. The whole pipeline
// moves together: it holds while a finished result waits under out_stall,
// and in_stall follows. Config may be written only when the pipeline is empty.
module color_line_projection_distance_core
    import clpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COLOR_W-1:0]    pixel_blue,
    input  wire logic [COLOR_W-1:0]    pixel_green,
    input  wire logic [COLOR_W-1:0]    pixel_red,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DIST_W-1:0]          projected_distance,
    output logic                       degenerate_line,
    output logic                       distance_saturated
);

    // calibrated colors, index 0 blue, 1 green, 2 red
    color_t bg_reg [3];
    color_t finger_reg [3];
    color_t pix [3];

    // pipeline advance: stops only when the output holds an untaken result
    logic en;

    logic       front_valid;
    div_data_t  front_data;

    logic       div_valid [Q_W+1];
    div_data_t  div_data  [Q_W+1];
    logic       sq_valid  [R_W+1];
    sqrt_data_t sq_data   [R_W+1];

    sqrt_data_t last;
    logic       sat;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // config write port, indexes past the last register are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bg_reg[i]     <= '0;
                finger_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BG_BLUE:      bg_reg[0]     <= cfg_data;
                REG_BG_GREEN:     bg_reg[1]     <= cfg_data;
                REG_BG_RED:       bg_reg[2]     <= cfg_data;
                REG_FINGER_BLUE:  finger_reg[0] <= cfg_data;
                REG_FINGER_GREEN: finger_reg[1] <= cfg_data;
                REG_FINGER_RED:   finger_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign pix[0] = pixel_blue;
    assign pix[1] = pixel_green;
    assign pix[2] = pixel_red;

    // line setup and numerator |P-B|^2 * d.d
    clpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .pix       (pix),
        .bg        (bg_reg),
        .finger    (finger_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    assign div_valid[0] = front_valid;
    assign div_data[0]  = front_data;

    // divider chain: numerator scaled by 2^(2*fraction) over d.d
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        clpd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // quotient seeds the square root chain
    always_comb
    begin
        sq_valid[0]      = div_valid[Q_W];
        sq_data[0].degen = div_data[Q_W].degen;
        sq_data[0].rem   = '0;
        sq_data[0].root  = '0;
        sq_data[0].xs    = div_data[Q_W].qx;
    end

    for (genvar k = 0; k < R_W; k++)
    begin : g_sqrt
        clpd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_data  (sq_data[k+1])
        );
    end

    // the last cell register is the output register
    assign last = sq_data[R_W];
    assign sat  = (R_W > DIST_W) && (32'(last.root) > 32'((1 << DIST_W) - 1));

    assign out_valid          = sq_valid[R_W];
    assign degenerate_line    = last.degen;
    assign distance_saturated = !last.degen && sat;
    assign projected_distance = last.degen ? '0 :
                                sat        ? {DIST_W{1'b1}} : DIST_W'(last.root);

endmodule

`default_nettype wire

@@ tb/color_line_projection_distance_core_test.sv @@
// color_line_projection_distance_core_test: self-checking bench for the color line core
// depends on clpd_pkg and color_line_projection_distance_core
`default_nettype none

module color_line_projection_distance_core_test;
    import clpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // wait longer than the pipeline depth before touching config
    localparam int DRAIN_CYCLES = 60;
    localparam int HANG_LIMIT   = 2000;

    typedef struct {
        color_t blue;
        color_t green;
        color_t red;
    } pixel_t;

    typedef struct {
        logic [DIST_W-1:0] dist_value;
        logic              degen;
        logic              sat;
    } distance_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BG_BLUE;
    logic [COLOR_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [COLOR_W-1:0] pixel_blue = '0;
    logic [COLOR_W-1:0] pixel_green = '0;
    logic [COLOR_W-1:0] pixel_red = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DIST_W-1:0] projected_distance;
    logic degenerate_line;
    logic distance_saturated;

    // bench copy of the calibrated colors, index 0 blue, 1 green, 2 red
    color_t bg_color[3];
    color_t finger_color[3];

    pixel_t    pending_pixels[$];
    distance_t expected_distances[$];
    int        error_count = 0;
    bit        idling_on = 1'b1;
    int        send_gap = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    color_line_projection_distance_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_blue(pixel_blue),
        .pixel_green(pixel_green),
        .pixel_red(pixel_red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .projected_distance(projected_distance),
        .degenerate_line(degenerate_line),
        .distance_saturated(distance_saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // floor of the square root, one root bit per step from the top
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // distance from background to the pixel projected onto the color line
    function automatic distance_t project_distance(pixel_t px);
        distance_t res;
        longint pix[3], start[3], dir[3], offs[3];
        longint norm_bg, norm_fg, dir_sq, along, offs_sq, offs_dir, scaled;
        longint unsigned quot, root;
        bit finger_start;
        pix[0] = px.blue;
        pix[1] = px.green;
        pix[2] = px.red;
        norm_bg = 0;
        norm_fg = 0;
        for (int i = 0; i < 3; i++)
        begin
            norm_bg += longint'(bg_color[i]) * bg_color[i];
            norm_fg += longint'(finger_color[i]) * finger_color[i];
        end
        // finger is the start point on equal norms
        finger_start = !(norm_bg < norm_fg);
        dir_sq = 0;
        along = 0;
        offs_sq = 0;
        offs_dir = 0;
        for (int i = 0; i < 3; i++)
        begin
            start[i] = finger_start ? finger_color[i] : bg_color[i];
            dir[i] = (finger_start ? longint'(bg_color[i]) : longint'(finger_color[i]))
                     - start[i];
            if (dir[i] < 0)
                dir[i] = 0;
            offs[i] = start[i] - bg_color[i];
            dir_sq += dir[i] * dir[i];
            along += dir[i] * (pix[i] - start[i]);
            offs_sq += offs[i] * offs[i];
            offs_dir += offs[i] * dir[i];
        end
        res.dist_value = '0;
        res.degen = 1'b0;
        res.sat = 1'b0;
        if (dir_sq == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        // squared distance times d.d, kept exact
        scaled = offs_sq * dir_sq + 2 * along * offs_dir + along * along;
        if (scaled < 0)
            scaled = 0;
        quot = ($unsigned(scaled) << (2 * FRACTION_BITS)) / $unsigned(dir_sq);
        root = floor_sqrt(quot);
        if (root > 65535)
        begin
            res.dist_value = 16'hFFFF;
            res.sat = 1'b1;
        end
        else
            res.dist_value = root[DIST_W-1:0];
        return res;
    endfunction

    // driver: present the oldest pending pixel, random gaps between transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_distances.push_back(project_distance(pending_pixels[0]));
                void'(pending_pixels.pop_front());
            end
            // a stalled payload stays put
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    in_valid <= 1'b1;
                    pixel_blue <= pending_pixels[0].blue;
                    pixel_green <= pending_pixels[0].green;
                    pixel_red <= pending_pixels[0].red;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall bursts, compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_distances.size() == 0)
                begin
                    $display("%0t: unexpected result distance=%0d degen=%0b sat=%0b", $time,
                             projected_distance, degenerate_line, distance_saturated);
                    error_count++;
                end
                else
                begin
                    distance_t want;
                    want = expected_distances.pop_front();
                    if (projected_distance !== want.dist_value)
                    begin
                        $display("%0t: projected_distance expected %0d actual %0d", $time,
                                 want.dist_value, projected_distance);
                        error_count++;
                    end
                    if (degenerate_line !== want.degen)
                    begin
                        $display("%0t: degenerate_line expected %0b actual %0b", $time,
                                 want.degen, degenerate_line);
                        error_count++;
                    end
                    if (distance_saturated !== want.sat)
                    begin
                        $display("%0t: distance_saturated expected %0b actual %0b", $time,
                                 want.sat, distance_saturated);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // watchdog: work outstanding but no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (pending_pixels.size() == 0 && expected_distances.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_reg(cfg_reg_t idx, color_t val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // write all six colors, only called with the pipeline empty
    task automatic set_colors(color_t bb, color_t bgr, color_t br,
                              color_t fb, color_t fgr, color_t fr);
        put_reg(REG_BG_BLUE, bb);
        put_reg(REG_BG_GREEN, bgr);
        put_reg(REG_BG_RED, br);
        put_reg(REG_FINGER_BLUE, fb);
        put_reg(REG_FINGER_GREEN, fgr);
        put_reg(REG_FINGER_RED, fr);
        @(posedge clk);
        cfg_write <= 1'b0;
        bg_color[0] = bb;
        bg_color[1] = bgr;
        bg_color[2] = br;
        finger_color[0] = fb;
        finger_color[1] = fgr;
        finger_color[2] = fr;
    endtask

    task automatic queue_pixel(color_t b, color_t g, color_t r);
        pixel_t px;
        px.blue = b;
        px.green = g;
        px.red = r;
        pending_pixels.push_back(px);
    endtask

    function automatic color_t rand_color(int lo, int hi);
        return color_t'($urandom_range(hi, lo));
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_pixel(rand_color(0, 255), rand_color(0, 255), rand_color(0, 255));
    endtask

    task automatic queue_corners();
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
    endtask

    task automatic wait_drained();
        wait (pending_pixels.size() == 0 && expected_distances.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            bg_color[i] = '0;
            finger_color[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset colors: zero direction, every pixel is degenerate
        queue_corners();
        wait_drained();

        // background black, finger white: longest line
        set_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        queue_corners();
        wait_drained();

        // background white: finger becomes the start, distances near the top
        set_colors(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        queue_corners();
        wait_drained();

        // equal norms, finger starts, direction from finger to background
        set_colors(8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd5);
        queue_corners();
        wait_drained();

        // identical colors give a zero direction
        set_colors(8'd77, 8'd12, 8'd200, 8'd77, 8'd12, 8'd200);
        queue_pixel(8'd10, 8'd20, 8'd30);
        wait_drained();

        // green clamps to zero, the direction keeps blue and red
        set_colors(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
        queue_corners();
        wait_drained();

        // random calibrations, mostly with idling, the last phase without
        for (int phase = 0; phase < 13; phase++)
        begin
            if (phase == 12)
                idling_on = 1'b0;
            if (phase % 4 == 3)
                set_colors(rand_color(0, 255), rand_color(0, 255),
                           rand_color(0, 255), rand_color(0, 255),
                           rand_color(0, 255), rand_color(0, 255));
            else if (phase % 4 == 1)
                // dark background against bright finger
                set_colors(rand_color(0, 40), rand_color(0, 40),
                           rand_color(0, 40), rand_color(200, 255),
                           rand_color(200, 255), rand_color(200, 255));
            else
                set_colors(rand_color(0, 255), rand_color(0, 255),
                           rand_color(0, 255), rand_color(0, 255),
                           rand_color(0, 255), rand_color(0, 255));
            queue_random(150);
            wait_drained();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/clpd_pkg.sv
rtl/clpd_front.sv
rtl/clpd_div_cell.sv
rtl/clpd_sqrt_cell.sv
rtl/color_line_projection_distance_core.sv
tb/color_line_projection_distance_core_test.sv
